// File: hw/rtl/cml_pkg.sv
package cml_pkg;

  // Default frame limits for the top level
  localparam int unsigned MAX_COLUMNS_DEF = 1024;
  localparam int unsigned MAX_ROWS_DEF    = 1024;

  // Register file
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 11;
  localparam int unsigned LEVEL_W     = 8;
  localparam int unsigned GEOM_W      = 11;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_LEVEL_LOW     = 2'd0,
    REG_LEVEL_HIGH    = 2'd1,
    REG_FRAME_COLUMNS = 2'd2,
    REG_FRAME_ROWS    = 2'd3
  } cfg_reg_t;

  localparam logic [LEVEL_W-1:0] LEVEL_LOW_RST     = 8'd200;
  localparam logic [LEVEL_W-1:0] LEVEL_HIGH_RST    = 8'd255;
  localparam logic [GEOM_W-1:0]  FRAME_COLUMNS_RST = 11'd640;
  localparam logic [GEOM_W-1:0]  FRAME_ROWS_RST    = 11'd480;

  // Result item
  localparam int unsigned OUT_IDX_W = 10;
  localparam int unsigned RES_DEPTH = 4;
  localparam int unsigned RES_PTR_W = 2;
  localparam int unsigned RES_CNT_W = 3;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] cross_col;
    logic                 col_found;
    logic [OUT_IDX_W-1:0] cross_row;
    logic                 row_found;
  } result_t;

endpackage

// File: hw/rtl/cross_marker_locator_core.sv
// Cross marker locator.
// Input beats (s_*) carry one 8-bit plane sample each, in raster order;
// s_tuser[0] marks the first pixel of a frame and returns the scan to row 0,
// column 0, dropping any partial frame. Pixels above level_low count as set
// when level_high is nonzero. Set pixels are counted per row and per column;
// the first row whose count is largest and above half the width, and the
// first column likewise above half the height, are reported.
// One output beat (m_*) follows the last pixel of each frame with both
// positions and their found flags. The cfg port writes the four registers
// and the user must use it only while no frame work is in flight; the block
// does not enforce this. Throughput: one pixel per cycle while s_tready is
// high, bounded by the single read-modify-write path of the column count
// memory (one read and one write per cycle, with forwarding of the entry
// written in the previous cycle). Stage 1 pushes each frame's result into a
// four-deep queue whose nonzero count raises m_tvalid; s_tready drops while
// that queue holds three unsent results, or two with a pixel in flight.
// Reset clears the registers to their defaults, the scan position and the
// queue; the column memory needs no clearing since row 0 writes it fresh.
module cross_marker_locator_core #(
  parameter int unsigned MAX_COLUMNS = cml_pkg::MAX_COLUMNS_DEF,
  parameter int unsigned MAX_ROWS    = cml_pkg::MAX_ROWS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // config write port
  input  logic                              cfg_we,
  input  logic [cml_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [cml_pkg::CFG_DATA_W-1:0]    cfg_data,
  // pixel input
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [7:0]                        s_tdata,   // [7:0] sample
  input  logic [0:0]                        s_tuser,   // [0] frame_start
  // result output
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [0] row_found, [10:1] cross_row, [11] col_found, [21:12] cross_col, [23:22] zero
  output logic [23:0]                       m_tdata
);

  localparam int unsigned XW  = $clog2(MAX_COLUMNS);
  localparam int unsigned YW  = $clog2(MAX_ROWS);
  localparam int unsigned CW  = $clog2(MAX_COLUMNS + 1);
  localparam int unsigned RW  = $clog2(MAX_ROWS + 1);
  localparam int unsigned ECW = (CW > cml_pkg::GEOM_W) ? CW : cml_pkg::GEOM_W;
  localparam int unsigned ERW = (RW > cml_pkg::GEOM_W) ? RW : cml_pkg::GEOM_W;
  localparam int unsigned OW  = cml_pkg::OUT_IDX_W;

  // Configuration registers
  logic [cml_pkg::LEVEL_W-1:0] level_low;
  logic [cml_pkg::LEVEL_W-1:0] level_high;
  logic [cml_pkg::GEOM_W-1:0]  frame_columns;
  logic [cml_pkg::GEOM_W-1:0]  frame_rows;

  always_ff @(posedge clk) begin
    if (rst) begin
      level_low     <= cml_pkg::LEVEL_LOW_RST;
      level_high    <= cml_pkg::LEVEL_HIGH_RST;
      frame_columns <= cml_pkg::FRAME_COLUMNS_RST;
      frame_rows    <= cml_pkg::FRAME_ROWS_RST;
    end else if (cfg_we) begin
      case (cml_pkg::cfg_reg_t'(cfg_index))
        cml_pkg::REG_LEVEL_LOW:     level_low     <= cfg_data[cml_pkg::LEVEL_W-1:0];
        cml_pkg::REG_LEVEL_HIGH:    level_high    <= cfg_data[cml_pkg::LEVEL_W-1:0];
        cml_pkg::REG_FRAME_COLUMNS: frame_columns <= cfg_data[cml_pkg::GEOM_W-1:0];
        cml_pkg::REG_FRAME_ROWS:    frame_rows    <= cfg_data[cml_pkg::GEOM_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp frame geometry to 1..MAX
  logic [ECW-1:0] cols_ext;
  logic [ERW-1:0] rows_ext;
  logic [CW-1:0]  eff_cols;
  logic [RW-1:0]  eff_rows;

  always_comb begin
    cols_ext = ECW'(frame_columns);
    rows_ext = ERW'(frame_rows);
    if (frame_columns == '0) begin
      eff_cols = CW'(1);
    end else if (cols_ext > ECW'(MAX_COLUMNS)) begin
      eff_cols = CW'(MAX_COLUMNS);
    end else begin
      eff_cols = CW'(cols_ext);
    end
    if (frame_rows == '0) begin
      eff_rows = RW'(1);
    end else if (rows_ext > ERW'(MAX_ROWS)) begin
      eff_rows = RW'(MAX_ROWS);
    end else begin
      eff_rows = RW'(rows_ext);
    end
  end

  // Stage 0: scan position, pixel decision, memory read
  logic [XW-1:0] pos_x;
  logic [YW-1:0] pos_y;
  logic [XW-1:0] px;
  logic [YW-1:0] py;
  logic          accept;
  logic          pix_set;
  logic          end_row;
  logic          last_row;

  assign accept   = s_tvalid && s_tready;
  assign px       = s_tuser[0] ? '0 : pos_x;
  assign py       = s_tuser[0] ? '0 : pos_y;
  assign pix_set  = (s_tdata > level_low) && (level_high != '0);
  assign end_row  = (CW'(px) + CW'(1)) >= eff_cols;
  assign last_row = (RW'(py) + RW'(1)) >= eff_rows;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x <= '0;
      pos_y <= '0;
    end else if (accept) begin
      if (end_row) begin
        pos_x <= '0;
        pos_y <= last_row ? '0 : py + 1'b1;
      end else begin
        pos_x <= px + 1'b1;
        pos_y <= py;
      end
    end
  end

  // Stage 1 registers
  logic          s1_valid;
  logic [XW-1:0] s1_x;
  logic [YW-1:0] s1_y;
  logic          s1_set;
  logic          s1_restart;
  logic          s1_row_start;
  logic          s1_first_row;
  logic          s1_end_row;
  logic          s1_last_row;
  logic          s1_fwd_hit;
  logic [RW-1:0] fwd_data;
  logic [RW-1:0] rdata;
  logic [RW-1:0] col_mem [MAX_COLUMNS];
  logic [RW-1:0] cc;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  // Capture the pixel and note a same-entry write in flight
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_x         <= px;
      s1_y         <= py;
      s1_set       <= pix_set;
      s1_restart   <= (px == '0) && (py == '0);
      s1_row_start <= (px == '0);
      s1_first_row <= (py == '0);
      s1_end_row   <= end_row;
      s1_last_row  <= last_row;
      s1_fwd_hit   <= s1_valid && (s1_x == px);
      fwd_data     <= cc;
    end
  end

  // Column count memory: read at accept, write back in stage 1
  always_ff @(posedge clk) begin
    if (accept) begin
      rdata <= col_mem[px];
    end
    if (s1_valid) begin
      col_mem[s1_x] <= cc;
    end
  end

  // Stage 1: update column count and the search
  logic [RW-1:0] col_base;
  logic [CW-1:0] row_count;
  logic [CW-1:0] rc;
  logic [CW-1:0] best_row_count;
  logic [YW-1:0] best_row_index;
  logic [RW-1:0] best_col_count;
  logic [XW-1:0] best_col_index;
  logic [1:0]    found_flags;
  logic [CW-1:0] brc_cur;
  logic [YW-1:0] bri_cur;
  logic [RW-1:0] bcc_cur;
  logic [XW-1:0] bci_cur;
  logic [1:0]    ff_cur;
  logic          row_upd;
  logic          col_upd;
  logic [CW-1:0] brc_next;
  logic [YW-1:0] bri_next;
  logic [RW-1:0] bcc_next;
  logic [XW-1:0] bci_next;
  logic [1:0]    ff_next;

  always_comb begin
    if (s1_first_row) begin
      col_base = '0;
    end else if (s1_fwd_hit) begin
      col_base = fwd_data;
    end else begin
      col_base = rdata;
    end
    cc = col_base + RW'(s1_set);
    rc = (s1_row_start ? '0 : row_count) + CW'(s1_set);

    brc_cur = s1_restart ? (eff_cols >> 1) : best_row_count;
    bri_cur = s1_restart ? '0 : best_row_index;
    bcc_cur = s1_restart ? (eff_rows >> 1) : best_col_count;
    bci_cur = s1_restart ? '0 : best_col_index;
    ff_cur  = s1_restart ? 2'b00 : found_flags;

    col_upd = s1_last_row && (cc > bcc_cur);
    row_upd = s1_end_row && (rc > brc_cur);

    bcc_next   = col_upd ? cc : bcc_cur;
    bci_next   = col_upd ? s1_x : bci_cur;
    brc_next   = row_upd ? rc : brc_cur;
    bri_next   = row_upd ? s1_y : bri_cur;
    ff_next    = ff_cur | {col_upd, row_upd};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count      <= '0;
      best_row_count <= '0;
      best_row_index <= '0;
      best_col_count <= '0;
      best_col_index <= '0;
      found_flags    <= '0;
    end else if (s1_valid) begin
      row_count      <= rc;
      best_row_count <= brc_next;
      best_row_index <= bri_next;
      best_col_count <= bcc_next;
      best_col_index <= bci_next;
      found_flags    <= ff_next;
    end
  end

  // Result at the last pixel of a frame
  cml_pkg::result_t              res;
  cml_pkg::result_t              out_res;
  logic                          res_push;
  logic [cml_pkg::RES_CNT_W-1:0] res_count;

  always_comb begin
    res.row_found = ff_next[0];
    res.cross_row = ff_next[0] ? OW'(bri_next) : '0;
    res.col_found = ff_next[1];
    res.cross_col = ff_next[1] ? OW'(bci_next) : '0;
  end

  assign res_push = s1_valid && s1_end_row && s1_last_row;

  cml_result_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_data (res),
    .pop       (m_tready),
    .valid     (m_tvalid),
    .data      (out_res),
    .count     (res_count)
  );

  // Hold input while the queue could not take the beat in flight
  assign s_tready = (res_count + cml_pkg::RES_CNT_W'(s1_valid))
                    < cml_pkg::RES_CNT_W'(cml_pkg::RES_DEPTH - 1);
  assign m_tdata  = {2'b00, out_res};

  a_stall_has_result: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with no result pending");

  a_start_restarts: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tuser[0]) |=> (s1_valid && s1_restart))
    else $error("frame start did not restart the search");

  a_fwd_after_write: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_fwd_hit) |-> $past(s1_valid))
    else $error("forwarding without a prior write");

  a_push_on_frame_end: assert property (@(posedge clk) disable iff (rst)
    (accept && end_row && last_row) |=> res_push)
    else $error("frame end gave no result");

endmodule

// File: hw/rtl/cml_result_fifo.sv
module cml_result_fifo (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  input  cml_pkg::result_t                   push_data,
  input  logic                               pop,
  output logic                               valid,
  output cml_pkg::result_t                   data,
  output logic [cml_pkg::RES_CNT_W-1:0]      count
);

  cml_pkg::result_t                  entries [cml_pkg::RES_DEPTH];
  logic [cml_pkg::RES_PTR_W-1:0]     wr_ptr;
  logic [cml_pkg::RES_PTR_W-1:0]     rd_ptr;
  logic                              do_pop;

  assign valid  = (count != '0);
  assign data   = entries[rd_ptr];
  assign do_pop = pop && valid;

  // Store pushed results
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count < cml_pkg::RES_CNT_W'(cml_pkg::RES_DEPTH)) || do_pop)
    else $error("result fifo overflow");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= cml_pkg::RES_CNT_W'(cml_pkg::RES_DEPTH))
    else $error("result fifo count out of range");

  a_pop_moves: assert property (@(posedge clk) disable iff (rst)
    (do_pop && !push) |=> (count == $past(count) - 1'b1))
    else $error("result fifo pop lost");

endmodule
